@@ src/poq_pkg.sv @@
// Shared types and codes for the priority-ordered process queue.
package poq_pkg;

  localparam int unsigned ID_BITS     = 5;
  localparam int unsigned OPCODE_BITS = 2;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned PRIO_W      = 8;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    logic [ID_BITS-1:0]     entry_id;
    logic [PRIO_W-1:0]      priority_req;
  } in_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     taken_id;
    logic [PRIO_W-1:0]      taken_prio;
    logic                   queue_empty;
    logic [ID_BITS-1:0]     head_id;
    logic [PRIO_W-1:0]      head_prio;
  } out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic do_insert;
    logic do_pop;
    logic do_delete;
  } ctl_t;

endpackage

@@ src/poq_cell.sv @@
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
module poq_cell import poq_pkg::*; #(
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_t                 ctl_i,
  input  logic [ID_BITS-1:0]   id_i,
  input  logic [PRIO_BITS-1:0] prio_i,
  input  logic                 left_valid_i,
  input  logic                 left_lower_i,
  input  logic [ID_BITS-1:0]   left_id_i,
  input  logic [PRIO_BITS-1:0] left_prio_i,
  input  logic                 right_valid_i,
  input  logic [ID_BITS-1:0]   right_id_i,
  input  logic [PRIO_BITS-1:0] right_prio_i,
  input  logic                 hit_i,
  output logic                 valid_o,
  output logic                 lower_o,
  output logic [ID_BITS-1:0]   id_o,
  output logic [PRIO_BITS-1:0] prio_o,
  output logic                 hit_o
);

  logic                 valid_q, valid_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic                 lower, match;

  // Slot is empty or holds strictly lower priority than the new entry.
  assign lower = !valid_q || (prio_i > prio_q);
  assign match = valid_q && (id_q == id_i);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    prio_d  = prio_q;
    if (ctl_i.do_pop || (ctl_i.do_delete && (hit_i || match))) begin
      // Close the gap: take the right neighbor's entry.
      valid_d = right_valid_i;
      id_d    = right_id_i;
      prio_d  = right_prio_i;
    end else if (ctl_i.do_insert && lower) begin
      if (left_lower_i) begin
        valid_d = valid_q || left_valid_i;
        id_d    = left_id_i;
        prio_d  = left_prio_i;
      end else begin
        valid_d = 1'b1;
        id_d    = id_i;
        prio_d  = prio_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign lower_o = lower;
  assign id_o    = id_q;
  assign prio_o  = prio_q;
  assign hit_o   = hit_i || match;

endmodule

@@ src/priority_ordered_process_queue.sv @@
// Priority-ordered process queue built as a chain of compare-and-shift cells.
// The result of each command is registered in the output register when the command transfers.
// Throughput: one command per cycle while no untaken result holds off the input, set by the shift of every cell.
// A waiting result that is not being taken holds off the input; a new command enters in the cycle it transfers.
// Reset empties the queue by clearing all slot valid bits at once.
module priority_ordered_process_queue import poq_pkg::*; #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic                 in_fire;
  op_e                  op;
  logic [ID_BITS-1:0]   cmd_id;
  logic [PRIO_BITS-1:0] cmd_prio;
  ctl_t                 ctl;

  logic [DEPTH-1:0]     cell_valid, cell_lower;
  logic [ID_BITS-1:0]   cell_id [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic [DEPTH:0]       hit;

  logic                 full, empty, found;
  logic [ID_BITS-1:0]   del_id;
  logic [PRIO_BITS-1:0] del_prio;

  out_t res;
  out_t out_q;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign op       = op_e'(in_data_i.opcode);
  assign cmd_id   = in_data_i.entry_id;
  assign cmd_prio = PRIO_BITS'({24'd0, in_data_i.priority_req});

  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];
  assign found = hit[DEPTH];

  assign ctl.do_insert = in_fire && (op == OP_INSERT) && !full;
  assign ctl.do_pop    = in_fire && (op == OP_POP);
  assign ctl.do_delete = in_fire && (op == OP_DELETE);

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_valid, l_lower, r_valid;
    logic [ID_BITS-1:0]   l_id, r_id;
    logic [PRIO_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_first
      assign l_valid = 1'b1;
      assign l_lower = 1'b0;
      assign l_id    = '0;
      assign l_prio  = '0;
    end else begin : g_mid
      assign l_valid = cell_valid[i-1];
      assign l_lower = cell_lower[i-1];
      assign l_id    = cell_id[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_id    = '0;
      assign r_prio  = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[i+1];
      assign r_id    = cell_id[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    poq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .id_i         (cmd_id),
      .prio_i       (cmd_prio),
      .left_valid_i (l_valid),
      .left_lower_i (l_lower),
      .left_id_i    (l_id),
      .left_prio_i  (l_prio),
      .right_valid_i(r_valid),
      .right_id_i   (r_id),
      .right_prio_i (r_prio),
      .hit_i        (hit[i]),
      .valid_o      (cell_valid[i]),
      .lower_o      (cell_lower[i]),
      .id_o         (cell_id[i]),
      .prio_o       (cell_prio[i]),
      .hit_o        (hit[i+1])
    );
  end

  // Select the entry at the first id match.
  always_comb begin
    del_id   = '0;
    del_prio = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (hit[i+1] && !hit[i]) begin
        del_id   = del_id | cell_id[i];
        del_prio = del_prio | cell_prio[i];
      end
    end
  end

  // Build the result, including the head as it stands after the command.
  always_comb begin
    logic                 hv;
    logic [ID_BITS-1:0]   hid;
    logic [PRIO_BITS-1:0] hpr;
    res        = '0;
    res.status = ST_OK;
    hv         = cell_valid[0];
    hid        = cell_id[0];
    hpr        = cell_prio[0];
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          res.taken_id   = cmd_id;
          res.taken_prio = PRIO_W'(cmd_prio);
          if (cell_lower[0]) begin
            hv  = 1'b1;
            hid = cmd_id;
            hpr = cmd_prio;
          end
        end
      end
      OP_POP: begin
        if (empty) begin
          res.status = ST_MISS;
        end else begin
          res.taken_id   = cell_id[0];
          res.taken_prio = PRIO_W'(cell_prio[0]);
          hv  = cell_valid[1];
          hid = cell_id[1];
          hpr = cell_prio[1];
        end
      end
      OP_DELETE: begin
        if (!found) begin
          res.status = ST_MISS;
        end else begin
          res.taken_id   = del_id;
          res.taken_prio = PRIO_W'(del_prio);
          if (hit[1]) begin
            hv  = cell_valid[1];
            hid = cell_id[1];
            hpr = cell_prio[1];
          end
        end
      end
      OP_NOP: begin
        res.status = ST_OK;
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.queue_empty = !hv;
    res.head_id     = hv ? hid : '0;
    res.head_prio   = hv ? PRIO_W'(hpr) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result until its transfer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ verif/priority_ordered_process_queue_tb.sv @@
// Self-checking testbench for the priority-ordered process queue: random traffic on both sides.
module priority_ordered_process_queue_tb;
  import poq_pkg::*;

  localparam int unsigned DEPTH          = 32;
  localparam int unsigned PRIO_BITS      = 8;
  localparam int unsigned RANDOM_CMDS    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_AT_RESULT = 150;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned DRAIN_AT_CMD   = 350;

  typedef struct packed {
    logic drain;
    in_t  cmd;
  } backlog_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // Shadow of the queue contents, head at index 0.
  logic [ID_BITS-1:0] shadow_id   [DEPTH];
  logic [PRIO_W-1:0]  shadow_prio [DEPTH];
  int unsigned        shadow_fill = 0;

  backlog_t    cmd_backlog [$];
  out_t        sched_replies [$];
  out_t        reply_want;
  logic        in_taken     = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned result_count = 0;
  int unsigned idle_cycles  = 0;
  int unsigned tx_gap       = 0;
  int unsigned tx_burst     = 0;
  int unsigned rx_gap       = 0;
  int unsigned rx_burst     = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;

  priority_ordered_process_queue #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Apply one command to the shadow queue and build the reply it produces.
  function automatic out_t apply_sched_cmd(in_t cmd);
    out_t        r;
    int unsigned pos;
    r = '0;
    r.status = ST_OK;
    case (op_e'(cmd.opcode))
      OP_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_fill && !(cmd.priority_req > shadow_prio[pos])) pos++;
          for (int i = shadow_fill; i > pos; i--) begin
            shadow_id[i]   = shadow_id[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_id[pos]   = cmd.entry_id;
          shadow_prio[pos] = cmd.priority_req;
          shadow_fill++;
          r.taken_id   = cmd.entry_id;
          r.taken_prio = cmd.priority_req;
        end
      end
      OP_POP, OP_DELETE: begin
        pos = 0;
        if (op_e'(cmd.opcode) == OP_DELETE) begin
          while (pos < shadow_fill && shadow_id[pos] != cmd.entry_id) pos++;
        end
        if (pos >= shadow_fill) begin
          r.status = ST_MISS;
        end else begin
          r.taken_id   = shadow_id[pos];
          r.taken_prio = shadow_prio[pos];
          for (int i = pos; i + 1 < shadow_fill; i++) begin
            shadow_id[i]   = shadow_id[i+1];
            shadow_prio[i] = shadow_prio[i+1];
          end
          shadow_fill--;
        end
      end
      default: ;
    endcase
    if (shadow_fill == 0) begin
      r.queue_empty = 1'b1;
    end else begin
      r.head_id   = shadow_id[0];
      r.head_prio = shadow_prio[0];
    end
    return r;
  endfunction

  task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_cmd(input op_e op, input int unsigned id, input int unsigned prio);
    backlog_t b;
    b.drain           = 1'b0;
    b.cmd.opcode      = op;
    b.cmd.entry_id    = id[ID_BITS-1:0];
    b.cmd.priority_req = prio[PRIO_W-1:0];
    cmd_backlog.push_back(b);
  endtask

  // Sender: hold the payload until transfer, then idle for a random gap outside bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
    end else if (tx_gap != 0) begin
      in_valid_i <= 1'b0;
      tx_gap     <= tx_gap - 1;
    end else if (cmd_backlog.size() == 0) begin
      in_valid_i <= 1'b0;
    end else if (cmd_backlog[0].drain) begin
      in_valid_i <= 1'b0;
      if (sched_replies.size() == 0) void'(cmd_backlog.pop_front());
    end else begin
      in_data_i  <= cmd_backlog[0].cmd;
      in_valid_i <= 1'b1;
      void'(cmd_backlog.pop_front());
      if (tx_burst != 0) begin
        tx_burst <= tx_burst - 1;
      end else begin
        if ($urandom_range(0, 49) == 0) tx_burst <= 30;
        tx_gap <= rand_gap();
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the block.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && result_count >= HOLD_AT_RESULT) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else if (rx_gap != 0) begin
      out_ready_i <= 1'b0;
      rx_gap      <= rx_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (rx_burst != 0) begin
        rx_burst <= rx_burst - 1;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_burst <= 40;
        rx_gap <= rand_gap();
      end
    end
  end

  // Monitor: check the result transfer first, then predict the input transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        result_count <= result_count + 1;
        if (sched_replies.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, out_data_o);
          mismatches++;
        end else begin
          reply_want = sched_replies.pop_front();
          cmp_field("status", reply_want.status, out_data_o.status);
          cmp_field("taken_id", reply_want.taken_id, out_data_o.taken_id);
          cmp_field("taken_prio", reply_want.taken_prio, out_data_o.taken_prio);
          cmp_field("queue_empty", reply_want.queue_empty, out_data_o.queue_empty);
          cmp_field("head_id", reply_want.head_id, out_data_o.head_id);
          cmp_field("head_prio", reply_want.head_prio, out_data_o.head_prio);
        end
      end
      if (in_valid_i && in_ready_o) sched_replies.push_back(apply_sched_cmd(in_data_i));
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned issued;
    int unsigned phase;
    int unsigned len;
    int unsigned r;
    int unsigned id;
    int unsigned prio;
    logic        drained;
    backlog_t    marker;
    op_e         op;

    // Directed: empty misses, no-op, extremes, ties, duplicate ids.
    queue_cmd(OP_POP, 0, 0);
    queue_cmd(OP_DELETE, 3, 0);
    queue_cmd(OP_NOP, 31, 255);
    queue_cmd(OP_INSERT, 0, 0);
    queue_cmd(OP_INSERT, 31, 255);
    queue_cmd(OP_INSERT, 5, 255);
    queue_cmd(OP_INSERT, 7, 128);
    queue_cmd(OP_INSERT, 7, 200);
    queue_cmd(OP_INSERT, 12, 0);
    queue_cmd(OP_DELETE, 7, 0);
    queue_cmd(OP_DELETE, 9, 0);
    queue_cmd(OP_DELETE, 0, 0);
    queue_cmd(OP_POP, 0, 0);
    queue_cmd(OP_NOP, 0, 0);
    queue_cmd(OP_POP, 0, 0);
    queue_cmd(OP_POP, 0, 0);
    queue_cmd(OP_POP, 0, 0);
    queue_cmd(OP_POP, 0, 0);
    queue_cmd(OP_INSERT, 31, 1);
    queue_cmd(OP_DELETE, 31, 0);

    // Random: fill, drain and mixed phases so the queue runs full and empty.
    issued  = 0;
    drained = 1'b0;
    while (issued < RANDOM_CMDS) begin
      phase = $urandom_range(0, 2);
      len   = $urandom_range(10, 60);
      repeat (len) begin
        r = $urandom_range(0, 99);
        case (phase)
          0:       op = (r < 85) ? OP_INSERT : (r < 92) ? OP_POP : (r < 97) ? OP_DELETE : OP_NOP;
          1:       op = (r < 60) ? OP_POP : (r < 85) ? OP_DELETE : (r < 95) ? OP_INSERT : OP_NOP;
          default: op = (r < 40) ? OP_INSERT : (r < 65) ? OP_POP : (r < 92) ? OP_DELETE : OP_NOP;
        endcase
        id   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
        prio = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
        queue_cmd(op, id, prio);
        issued++;
      end
      if (!drained && issued >= DRAIN_AT_CMD) begin
        marker       = '0;
        marker.drain = 1'b1;
        cmd_backlog.push_back(marker);
        drained      = 1'b1;
      end
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid_i || sched_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    if (mismatches == 0 && sched_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
